### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that b holds in the same cycle as a.
`define ASSERT_SAME(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error(msg);

// Check that b holds in the cycle after a.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error(msg);

`endif

### rtl/core/jrs_pkg.sv
package jrs_pkg;

   typedef struct packed {
      logic [15:0] job_id;
      logic [15:0] arrival_time;
      logic [15:0] job_duration;
      logic [15:0] expire_time;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_KEY,
      ST_CMP,
      ST_PLACE,
      ST_EMIT
   } state_type;

   // True when a must come strictly after b.
   function automatic logic rec_after(input rec_type a, input rec_type b);
      logic res;
      if (a.arrival_time != b.arrival_time) begin
         res = a.arrival_time > b.arrival_time;
      end else begin
         res = a.job_id > b.job_id;
      end
      return res;
   endfunction

endpackage

### rtl/core/job_record_sorter.sv
// Loading: one record word per cycle, busy low, no result.
// After the last word: a setup state (ST_START), then an in-place insertion sort in the record RAM:
// each record after the first is latched (ST_KEY), later neighbors shift right (ST_CMP).
// Output: one sorted word per cycle on rsp_strobe, read in ST_EMIT and registered.
// The receiver cannot stall; busy falls in the same cycle as the final word is shown.
// Synchronous reset empties the set and clears the overflow flag; RAM contents are kept.
`include "assert_macros.svh"

module job_record_sorter #(
   parameter int MAX_RECORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_job_id,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_job_duration,
   input  logic [15:0] req_expire_time,
   input  logic        req_last_record,
   output logic        rsp_strobe,
   output logic [15:0] rsp_out_job_id,
   output logic [15:0] rsp_out_arrival_time,
   output logic [15:0] rsp_out_job_duration,
   output logic [15:0] rsp_out_expire_time,
   output logic        rsp_out_last,
   output logic        rsp_overflowed
);

   localparam int ADDR_W = $clog2(MAX_RECORDS);
   localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RECORDS);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO     = CNT_W'(2);

   jrs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   jrs_pkg::rec_type   key_ff, key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   jrs_pkg::rec_type   rsp_rec_ff, rsp_rec_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;
   logic               fwd_hit_ff, fwd_hit_in;
   jrs_pkg::rec_type   fwd_rec_ff, fwd_rec_in;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   jrs_pkg::rec_type          wr_data;
   logic [ADDR_W-1:0]         rd_addr;
   logic [jrs_pkg::REC_W-1:0] rd_raw;
   jrs_pkg::rec_type          rd_rec;
   jrs_pkg::rec_type          req_rec;
   logic [CNT_W-1:0]          i_next;
   logic [CNT_W-1:0]          k_next;

   // a read of the entry written in the same cycle returns the new word
   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);
   assign fwd_rec_in = wr_data;
   assign rd_rec  = fwd_hit_ff ? fwd_rec_ff : jrs_pkg::rec_type'(rd_raw);
   assign req_rec = '{job_id: req_job_id, arrival_time: req_arrival_time,
                      job_duration: req_job_duration, expire_time: req_expire_time};
   assign i_next  = i_ff + ONE;
   assign k_next  = k_ff + ONE;

   jrs_ram #(
      .WIDTH(jrs_pkg::REC_W),
      .DEPTH(MAX_RECORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jrs_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      key_ff      <= key_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_rec_ff  <= fwd_rec_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      key_in       = key_ff;
      rsp_valid_in = 1'b0;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_rec;
      rd_addr      = '0;

      case (state_ff)
         jrs_pkg::ST_LOAD: begin
            if (start) begin
               if (count_ff < MAX_CNT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_record) begin
                  state_in = jrs_pkg::ST_START;
               end
            end
         end
         jrs_pkg::ST_START: begin
            if (count_ff >= TWO) begin
               rd_addr  = ADDR_W'(1);
               i_in     = ONE;
               state_in = jrs_pkg::ST_KEY;
            end else begin
               k_in     = '0;
               state_in = jrs_pkg::ST_EMIT;
            end
         end
         jrs_pkg::ST_KEY: begin
            // latch the record to insert, fetch its left neighbor
            key_in   = rd_rec;
            rd_addr  = ADDR_W'(i_ff - ONE);
            j_in     = i_ff;
            state_in = jrs_pkg::ST_CMP;
         end
         jrs_pkg::ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[ADDR_W-1:0];
            if (jrs_pkg::rec_after(rd_rec, key_ff)) begin
               // shift neighbor right, fetch the next one unless at the front
               wr_data = rd_rec;
               j_in    = j_ff - ONE;
               if (j_ff == ONE) begin
                  state_in = jrs_pkg::ST_PLACE;
               end else begin
                  rd_addr = ADDR_W'(j_ff - TWO);
               end
            end else begin
               wr_data = key_ff;
               if (i_next < count_ff) begin
                  rd_addr  = i_next[ADDR_W-1:0];
                  i_in     = i_next;
                  state_in = jrs_pkg::ST_KEY;
               end else begin
                  k_in     = '0;
                  state_in = jrs_pkg::ST_EMIT;
               end
            end
         end
         jrs_pkg::ST_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key_ff;
            if (i_next < count_ff) begin
               rd_addr  = i_next[ADDR_W-1:0];
               i_in     = i_next;
               state_in = jrs_pkg::ST_KEY;
            end else begin
               k_in     = '0;
               state_in = jrs_pkg::ST_EMIT;
            end
         end
         jrs_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_rec_in   = rd_rec;
            rsp_last_in  = (k_next == count_ff);
            rsp_ovf_in   = ovf_ff;
            if (k_next == count_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = jrs_pkg::ST_LOAD;
            end else begin
               rd_addr = k_next[ADDR_W-1:0];
               k_in    = k_next;
            end
         end
         default: begin
            state_in = jrs_pkg::ST_LOAD;
         end
      endcase
   end

   assign busy                 = (state_ff != jrs_pkg::ST_LOAD);
   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_out_job_id       = rsp_rec_ff.job_id;
   assign rsp_out_arrival_time = rsp_rec_ff.arrival_time;
   assign rsp_out_job_duration = rsp_rec_ff.job_duration;
   assign rsp_out_expire_time  = rsp_rec_ff.expire_time;
   assign rsp_out_last         = rsp_last_ff;
   assign rsp_overflowed       = rsp_ovf_ff;

   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT, "record count overran")
   `ASSERT_SAME(a_sort_write_in_set, clock, reset, wr_en && busy,
      CNT_W'(wr_addr) < count_ff, "sort write outside the stored set")
   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_strobe && rsp_out_last,
      !rsp_strobe, "word after the final word of a set")

endmodule

### rtl/core/jrs_ram.sv
module jrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### test/tb.sv
`timescale 1ns / 1ps

// One output word as the sorter should present it.
typedef struct {
   jrs_pkg::rec_type rec;
   logic             last;
   logic             ovf;
} due_word_type;

class job_order_board;
   int capacity;
   jrs_pkg::rec_type open_set[$];
   logic             set_dropped;
   due_word_type     sorted_due[$];
   int               mismatches;

   function new(int cap);
      capacity    = cap;
      set_dropped = 1'b0;
      mismatches  = 0;
   endfunction

   // Primary key arrival time, then identifier; equal keys are not "later".
   function bit comes_later(jrs_pkg::rec_type a, jrs_pkg::rec_type b);
      if (a.arrival_time != b.arrival_time) begin
         return a.arrival_time > b.arrival_time;
      end
      return a.job_id > b.job_id;
   endfunction

   function int pending();
      return sorted_due.size();
   endfunction

   function void note_record(jrs_pkg::rec_type r, logic last);
      jrs_pkg::rec_type ordered[$];
      jrs_pkg::rec_type hold;
      due_word_type     w;
      int               j;
      if (open_set.size() < capacity) begin
         open_set = {open_set, r};
      end else begin
         set_dropped = 1'b1;
      end
      if (!last) begin
         return;
      end
      ordered = open_set;
      // stable insertion sort
      for (int i = 1; i < ordered.size(); i++) begin
         hold = ordered[i];
         j = i;
         while (j > 0 && comes_later(ordered[j-1], hold)) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = hold;
      end
      for (int k = 0; k < ordered.size(); k++) begin
         w.rec  = ordered[k];
         w.last = (k == ordered.size() - 1);
         w.ovf  = set_dropped;
         sorted_due = {sorted_due, w};
      end
      open_set.delete();
      set_dropped = 1'b0;
   endfunction

   function void check_output(jrs_pkg::rec_type got, logic got_last, logic got_ovf);
      due_word_type want;
      if (sorted_due.size() == 0) begin
         $error("unexpected output word, job_id %h arrival_time %h",
                got.job_id, got.arrival_time);
         mismatches++;
         return;
      end
      want = sorted_due.pop_front();
      if (got.job_id !== want.rec.job_id) begin
         $error("out_job_id: expected %h, actual %h", want.rec.job_id, got.job_id);
         mismatches++;
      end
      if (got.arrival_time !== want.rec.arrival_time) begin
         $error("out_arrival_time: expected %h, actual %h",
                want.rec.arrival_time, got.arrival_time);
         mismatches++;
      end
      if (got.job_duration !== want.rec.job_duration) begin
         $error("out_job_duration: expected %h, actual %h",
                want.rec.job_duration, got.job_duration);
         mismatches++;
      end
      if (got.expire_time !== want.rec.expire_time) begin
         $error("out_expire_time: expected %h, actual %h",
                want.rec.expire_time, got.expire_time);
         mismatches++;
      end
      if (got_last !== want.last) begin
         $error("out_last: expected %b, actual %b", want.last, got_last);
         mismatches++;
      end
      if (got_ovf !== want.ovf) begin
         $error("overflowed: expected %b, actual %b", want.ovf, got_ovf);
         mismatches++;
      end
   endfunction
endclass

module tb;
   localparam int CAPACITY    = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 295;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [15:0] req_job_id;
   logic [15:0] req_arrival_time;
   logic [15:0] req_job_duration;
   logic [15:0] req_expire_time;
   logic        req_last_record;
   logic        rsp_strobe;
   logic [15:0] rsp_out_job_id;
   logic [15:0] rsp_out_arrival_time;
   logic [15:0] rsp_out_job_duration;
   logic [15:0] rsp_out_expire_time;
   logic        rsp_out_last;
   logic        rsp_overflowed;

   job_order_board board;
   int             cycle_count = 0;
   int             idle_pct;
   int             random_sent;

   job_record_sorter #(
      .MAX_RECORDS(CAPACITY)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_job_id           (req_job_id),
      .req_arrival_time     (req_arrival_time),
      .req_job_duration     (req_job_duration),
      .req_expire_time      (req_expire_time),
      .req_last_record      (req_last_record),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_job_id       (rsp_out_job_id),
      .rsp_out_arrival_time (rsp_out_arrival_time),
      .rsp_out_job_duration (rsp_out_job_duration),
      .rsp_out_expire_time  (rsp_out_expire_time),
      .rsp_out_last         (rsp_out_last),
      .rsp_overflowed       (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Note each accepted record word.
   always @(posedge clock) begin
      jrs_pkg::rec_type r;
      if (!reset && start && !busy) begin
         r.job_id       = req_job_id;
         r.arrival_time = req_arrival_time;
         r.job_duration = req_job_duration;
         r.expire_time  = req_expire_time;
         board.note_record(r, req_last_record);
      end
   end

   // Check each sorted word as it is shown.
   always @(posedge clock) begin
      jrs_pkg::rec_type r;
      if (!reset && rsp_strobe) begin
         r.job_id       = rsp_out_job_id;
         r.arrival_time = rsp_out_arrival_time;
         r.job_duration = rsp_out_job_duration;
         r.expire_time  = rsp_out_expire_time;
         board.check_output(r, rsp_out_last, rsp_overflowed);
      end
   end

   function automatic jrs_pkg::rec_type mk(logic [15:0] id, logic [15:0] arr,
                                            logic [15:0] dur, logic [15:0] tmo);
      jrs_pkg::rec_type r;
      r.job_id       = id;
      r.arrival_time = arr;
      r.job_duration = dur;
      r.expire_time  = tmo;
      return r;
   endfunction

   // Narrow key modes force ties and duplicate keys.
   function automatic jrs_pkg::rec_type draw_record(int mode);
      logic [15:0] picks [4];
      jrs_pkg::rec_type r;
      picks[0] = 16'h0000;
      picks[1] = 16'h0001;
      picks[2] = 16'hFFFF;
      picks[3] = 16'h8000;
      r = mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      case (mode)
         1: begin
            r.job_id       = picks[$urandom_range(0, 3)];
            r.arrival_time = picks[$urandom_range(0, 3)];
         end
         2: begin
            r.arrival_time = 16'($urandom_range(0, 3));
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_word(input jrs_pkg::rec_type r, input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_job_id       <= r.job_id;
      req_arrival_time <= r.arrival_time;
      req_job_duration <= r.job_duration;
      req_expire_time  <= r.expire_time;
      req_last_record  <= last;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic send_set(input int size, input int mode);
      for (int k = 0; k < size; k++) begin
         send_word(draw_record(mode), k == size - 1);
         random_sent++;
      end
   endtask

   task automatic wait_drain();
      // drop start so the last word is not taken again once busy falls
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() > 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int set_idx;
      int size;
      board            = new(CAPACITY);
      idle_pct         = 38;
      random_sent      = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_job_id       = '0;
      req_arrival_time = '0;
      req_job_duration = '0;
      req_expire_time  = '0;
      req_last_record  = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-record sets at the field extremes
      send_word(mk(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1);
      send_word(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
      // reverse arrival order
      send_word(mk(16'h0001, 16'hFFFF, 16'hAAAA, 16'h5555), 1'b0);
      send_word(mk(16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA), 1'b0);
      send_word(mk(16'h8000, 16'h0001, 16'h0F0F, 16'hF0F0), 1'b0);
      send_word(mk(16'h7FFF, 16'h0000, 16'hF0F0, 16'h0F0F), 1'b1);
      // equal arrival, identifier breaks the tie
      send_word(mk(16'hFFFF, 16'h1234, 16'h0001, 16'h0002), 1'b0);
      send_word(mk(16'h0000, 16'h1234, 16'h0003, 16'h0004), 1'b0);
      send_word(mk(16'h7FFF, 16'h1234, 16'h0005, 16'h0006), 1'b0);
      send_word(mk(16'h8000, 16'h1234, 16'h0007, 16'h0008), 1'b1);
      // equal on both keys: input order must hold
      send_word(mk(16'h4242, 16'h0100, 16'h0001, 16'hFFFF), 1'b0);
      send_word(mk(16'h4242, 16'h0100, 16'h0002, 16'hFFFE), 1'b0);
      send_word(mk(16'h4241, 16'h0100, 16'h0003, 16'hFFFD), 1'b0);
      send_word(mk(16'h4242, 16'h0100, 16'h0004, 16'hFFFC), 1'b1);
      // already in order
      send_word(mk(16'h0003, 16'h0001, 16'h1111, 16'h2222), 1'b0);
      send_word(mk(16'h0002, 16'h0002, 16'h3333, 16'h4444), 1'b0);
      send_word(mk(16'h0001, 16'h0003, 16'h5555, 16'h6666), 1'b1);

      set_idx = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // long stretch without sender gaps
         idle_pct = (set_idx >= 4 && set_idx < 10) ? 0 : 38;
         case (set_idx)
            3:       size = CAPACITY;
            7:       size = CAPACITY + 1;
            11:      size = CAPACITY + $urandom_range(2, 6);
            default: size = $urandom_range(1, 8);
         endcase
         send_set(size, $urandom_range(0, 2));
         if (set_idx == 5 || set_idx == 12) begin
            wait_drain();
         end
         set_idx++;
      end
      @(negedge clock);
      start <= 1'b0;

      wait_drain();
      repeat (100) @(posedge clock);
      if (board.pending() > 0) begin
         $error("%0d sorted words never arrived", board.pending());
      end
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### job_record_sorter.f
+incdir+rtl/core
rtl/core/jrs_pkg.sv
rtl/core/jrs_ram.sv
rtl/core/job_record_sorter.sv
test/tb.sv
